// ----- src/q2e_pkg.sv -----
// Shared constants, types and tables for the quaternion to Euler angle unit.
// No dependencies; the files that use it refer to it by scoped names.
package q2e_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 20;
    localparam int DEG_FRAC        = 24;
    localparam int ISQRT_STAGES    = 31;
    localparam int CORDIC_XW       = 35;
    localparam int ANGLE_W         = 34;
    localparam int RND_SHIFT       = DEG_FRAC - ANGLE_FRAC_BITS;
    localparam int PIPE_DEPTH      = 2 * ISQRT_STAGES + CORDIC_STAGES + 10;

    localparam logic signed [ANGLE_W-1:0] DEG90_Q24 = ANGLE_W'(90) <<< DEG_FRAC;

    // atan(2^-i) in degrees, Q24
    localparam logic [29:0] ATAN_TAB [0:31] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
        30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
        30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
        30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
        30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [31:0] roll_y;
        logic signed [31:0] roll_x;
        logic signed [31:0] yaw_y;
        logic signed [31:0] yaw_x;
        logic signed [31:0] ts;
    } ang_ops_t;

endpackage

// ----- src/q2e_in_if.sv -----
// Request channel carrying one quaternion sample.
// Depends on nothing; used by the top level.
interface q2e_in_if;
    logic               valid;
    logic               ready;
    logic               quat_valid;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source (output valid, quat_valid, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_valid, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- src/q2e_out_if.sv -----
// Request channel carrying one set of Euler angles.
// Depends on nothing; used by the top level.
interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [16:0] yaw_deg;

    modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
    modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

// ----- src/quaternion_to_euler_angles_unit.sv -----
// Top level: quaternion vector part to roll, pitch and yaw in degrees.
// Depends on q2e_pkg, q2e_in_if, q2e_out_if, q2e_isqrt and q2e_cordic.
//
//   port     | direction | payload
//   ---------+-----------+------------------------------------------------
//   samples  | in        | quat_valid, quat_x, quat_y, quat_z (Q30)
//   angles   | out       | roll_deg, pitch_deg, yaw_deg (degrees * 256)
//
// One request enters per cycle while the pipe is not stalled; the delay to
// a result is set chiefly by the two chained square root pipelines and the
// CORDIC stages.
// A request with quat_valid low is taken and dropped; it yields no result.
// Reset clears only the valid bits; data registers carry no reset.
// The whole pipe stalls only when its last stage and the output register
// both hold results and the sink is not ready; otherwise every stage advances.
module quaternion_to_euler_angles_unit (
    input  logic            clk,
    input  logic            rst_n,
    q2e_in_if.sink          samples,
    q2e_out_if.source       angles
);
    localparam int D   = q2e_pkg::PIPE_DEPTH;
    localparam int NQ  = q2e_pkg::ISQRT_STAGES;
    localparam int AW  = q2e_pkg::ANGLE_W;
    localparam int RS  = q2e_pkg::RND_SHIFT;
    localparam int AFB = q2e_pkg::ANGLE_FRAC_BITS;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;
    localparam logic signed [63:0] HALF_Q30 = 64'sd1 <<< 29;
    localparam logic signed [AW-1:0] HALF_OUT = AW'(1) <<< (RS - 1);
    localparam logic signed [AW-1:0] LIM180 = AW'(180) <<< AFB;
    localparam logic signed [AW-1:0] LIM90  = AW'(90) <<< AFB;

    logic en;
    logic vld_reg [0:D-1];
    logic ov_reg;
    logic ov_next;
    logic load_out;

    // stall only when both the last stage and the output register are full
    assign en       = !vld_reg[D-1] || !ov_reg || angles.ready;
    assign load_out = vld_reg[D-1] && (!ov_reg || angles.ready);
    assign samples.ready = en;

    always_comb
    begin
        ov_next = ov_reg;
        if (load_out)
            ov_next = 1'b1;
        else if (angles.ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
                vld_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                // drop requests whose sample flag is clear
                vld_reg[0] <= samples.valid && samples.quat_valid;
                for (int i = 1; i < D; i++)
                    vld_reg[i] <= vld_reg[i-1];
            end
            ov_reg <= ov_next;
        end
    end

    function automatic logic signed [31:0] sat_q30(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (v > ONE_Q30)
            r = ONE_Q30;
        else if (v < -ONE_Q30)
            r = -ONE_Q30;
        return r;
    endfunction

    // stage 1: saturate components
    q2e_pkg::vec_t v1_reg;
    // stage 2: squares
    q2e_pkg::vec_t v2_reg;
    logic signed [63:0] xx2_reg, yy2_reg, zz2_reg;
    // stage 3: radicand of w
    q2e_pkg::vec_t v3_reg;
    logic [60:0]   rad3_reg;
    logic [63:0]   sum3;

    assign sum3 = 64'(xx2_reg) + 64'(yy2_reg) + 64'(zz2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg.x <= sat_q30(samples.quat_x);
            v1_reg.y <= sat_q30(samples.quat_y);
            v1_reg.z <= sat_q30(samples.quat_z);
            v2_reg   <= v1_reg;
            xx2_reg  <= v1_reg.x * v1_reg.x;
            yy2_reg  <= v1_reg.y * v1_reg.y;
            zz2_reg  <= v1_reg.z * v1_reg.z;
            v3_reg   <= v2_reg;
            // norm at or above one: take w as zero
            if (sum3 >= 64'(ONE_Q60))
                rad3_reg <= '0;
            else
                rad3_reg <= 61'(64'(ONE_Q60) - sum3);
        end
    end

    logic [30:0] w_root;

    q2e_isqrt u_isqrt_w (
        .clk  (clk),
        .en   (en),
        .rad  (rad3_reg),
        .root (w_root)
    );

    // hold the components beside the square root
    q2e_pkg::vec_t vd_reg [0:NQ-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < NQ; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    // stage 4: products, stage 5: t terms, stage 6: CORDIC operands
    logic signed [31:0] w_s;
    logic signed [63:0] wx4_reg, yz4_reg, wy4_reg, zx4_reg, wz4_reg, xy4_reg;
    logic signed [63:0] xx4_reg, yy4_reg, zz4_reg;
    logic signed [63:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [63:0] t2_raw;
    logic signed [63:0] ts_raw;
    q2e_pkg::ang_ops_t  op6_reg, op7_reg, op8_reg;
    logic signed [63:0] tsq7_reg;
    logic [60:0]        rad8_reg;

    assign w_s    = {1'b0, w_root};
    assign t2_raw = (wy4_reg - zx4_reg) <<< 1;
    assign ts_raw = (t2_reg + HALF_Q30) >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx4_reg <= w_s * vd_reg[NQ-1].x;
            yz4_reg <= vd_reg[NQ-1].y * vd_reg[NQ-1].z;
            wy4_reg <= w_s * vd_reg[NQ-1].y;
            zx4_reg <= vd_reg[NQ-1].z * vd_reg[NQ-1].x;
            wz4_reg <= w_s * vd_reg[NQ-1].z;
            xy4_reg <= vd_reg[NQ-1].x * vd_reg[NQ-1].y;
            xx4_reg <= vd_reg[NQ-1].x * vd_reg[NQ-1].x;
            yy4_reg <= vd_reg[NQ-1].y * vd_reg[NQ-1].y;
            zz4_reg <= vd_reg[NQ-1].z * vd_reg[NQ-1].z;

            t0_reg <= (wx4_reg + yz4_reg) <<< 1;
            t1_reg <= ONE_Q60 - ((xx4_reg + yy4_reg) <<< 1);
            t3_reg <= (wz4_reg + xy4_reg) <<< 1;
            t4_reg <= ONE_Q60 - ((yy4_reg + zz4_reg) <<< 1);
            if (t2_raw > ONE_Q60)
                t2_reg <= ONE_Q60;
            else if (t2_raw < -ONE_Q60)
                t2_reg <= -ONE_Q60;
            else
                t2_reg <= t2_raw;

            // atan2 operands floored to Q28; asin argument rounded to Q30
            op6_reg.roll_y <= 32'(t0_reg >>> 32);
            op6_reg.roll_x <= 32'(t1_reg >>> 32);
            op6_reg.yaw_y  <= 32'(t3_reg >>> 32);
            op6_reg.yaw_x  <= 32'(t4_reg >>> 32);
            if (ts_raw > 64'(ONE_Q30))
                op6_reg.ts <= ONE_Q30;
            else if (ts_raw < -64'(ONE_Q30))
                op6_reg.ts <= -ONE_Q30;
            else
                op6_reg.ts <= 32'(ts_raw);

            op7_reg  <= op6_reg;
            tsq7_reg <= op6_reg.ts * op6_reg.ts;
            op8_reg  <= op7_reg;
            rad8_reg <= 61'(ONE_Q60 - tsq7_reg);
        end
    end

    logic [30:0] c_root;

    q2e_isqrt u_isqrt_c (
        .clk  (clk),
        .en   (en),
        .rad  (rad8_reg),
        .root (c_root)
    );

    q2e_pkg::ang_ops_t od_reg [0:NQ-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            od_reg[0] <= op8_reg;
            for (int i = 1; i < NQ; i++)
                od_reg[i] <= od_reg[i-1];
        end
    end

    logic signed [AW-1:0] roll_a, pitch_a, yaw_a;

    q2e_cordic u_cordic_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (od_reg[NQ-1].roll_y),
        .x_in  (od_reg[NQ-1].roll_x),
        .angle (roll_a)
    );

    q2e_cordic u_cordic_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (od_reg[NQ-1].ts),
        .x_in  ({1'b0, c_root}),
        .angle (pitch_a)
    );

    q2e_cordic u_cordic_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (od_reg[NQ-1].yaw_y),
        .x_in  (od_reg[NQ-1].yaw_x),
        .angle (yaw_a)
    );

    function automatic logic signed [AW-1:0] round_sat(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] lim
    );
        logic signed [AW-1:0] r;
        r = (a + HALF_OUT) >>> RS;
        if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return r;
    endfunction

    // last stage: round to output precision and clamp residue overshoot
    logic signed [AW-1:0] roll_r_reg, pitch_r_reg, yaw_r_reg;
    logic signed [16:0]   roll_o_reg, yaw_o_reg;
    logic signed [15:0]   pitch_o_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_r_reg  <= round_sat(roll_a, LIM180);
            pitch_r_reg <= round_sat(pitch_a, LIM90);
            yaw_r_reg   <= round_sat(yaw_a, LIM180);
        end
        if (load_out)
        begin
            roll_o_reg  <= roll_r_reg[16:0];
            pitch_o_reg <= pitch_r_reg[15:0];
            yaw_o_reg   <= yaw_r_reg[16:0];
        end
    end

    assign angles.valid     = ov_reg;
    assign angles.roll_deg  = roll_o_reg;
    assign angles.pitch_deg = pitch_o_reg;
    assign angles.yaw_deg   = yaw_o_reg;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> (vld_reg[D-1] && ov_reg && !angles.ready))
        else $error("pipeline stalled with room downstream");

    a_drop_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready && !samples.quat_valid) |=> !vld_reg[0])
        else $error("sample with clear flag entered the pipeline");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid |-> (angles.roll_deg <= 17'sd46080 && angles.roll_deg >= -17'sd46080))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid |-> (angles.pitch_deg <= 16'sd23040
            && angles.pitch_deg >= -16'sd23040))
        else $error("pitch out of range");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> ov_reg)
        else $error("result lost at output register");
`endif

endmodule

// ----- src/q2e_isqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
// Depends on q2e_pkg.
module q2e_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [60:0] rad,
    output logic [30:0] root
);
    localparam int N = q2e_pkg::ISQRT_STAGES;

    logic [63:0] n_reg [0:N-1];
    logic [63:0] r_reg [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (2 * (N - 1 - k));
        logic [63:0] n_src;
        logic [63:0] r_src;
        logic [63:0] trial;

        if (k == 0) begin : g_first
            assign n_src = {3'b000, rad};
            assign r_src = '0;
        end
        else begin : g_next
            assign n_src = n_reg[k-1];
            assign r_src = r_reg[k-1];
        end

        assign trial = r_src + BIT;

        // take the bit when the remainder covers it, else just halve
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_src >= trial)
                begin
                    n_reg[k] <= n_src - trial;
                    r_reg[k] <= (r_src >> 1) + BIT;
                end
                else
                begin
                    n_reg[k] <= n_src;
                    r_reg[k] <= r_src >> 1;
                end
            end
        end
    end

    assign root = r_reg[N-1][30:0];
endmodule

// ----- src/q2e_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees, Q24.
// Depends on q2e_pkg for the stage count, widths and arctangent table.
module q2e_cordic (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [31:0]                    y_in,
    input  logic signed [31:0]                    x_in,
    output logic signed [q2e_pkg::ANGLE_W-1:0]    angle
);
    localparam int N  = q2e_pkg::CORDIC_STAGES;
    localparam int XW = q2e_pkg::CORDIC_XW;
    localparam int AW = q2e_pkg::ANGLE_W;

    logic signed [XW-1:0] x_reg [0:N];
    logic signed [XW-1:0] y_reg [0:N];
    logic signed [AW-1:0] a_reg [0:N];

    // fold the left half plane onto the right with a quarter turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0] <= XW'(y_in);
                    y_reg[0] <= -XW'(x_in);
                    a_reg[0] <= q2e_pkg::DEG90_Q24;
                end
                else
                begin
                    x_reg[0] <= -XW'(y_in);
                    y_reg[0] <= XW'(x_in);
                    a_reg[0] <= -q2e_pkg::DEG90_Q24;
                end
            end
            else
            begin
                x_reg[0] <= XW'(x_in);
                y_reg[0] <= XW'(y_in);
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [AW-1:0] STEP = {{(AW-30){1'b0}}, q2e_pkg::ATAN_TAB[i]};
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    a_reg[i+1] <= a_reg[i] + STEP;
                end
                else if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    a_reg[i+1] <= a_reg[i] - STEP;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    a_reg[i+1] <= a_reg[i];
                end
            end
        end
    end

    assign angle = a_reg[N];
endmodule

// ----- bench/q2e_tb_pkg.sv -----
// Testbench-side predictor of the quaternion to Euler angle conversion.
// Depends on q2e_pkg for the angle table, stage count and fraction widths.
package q2e_tb_pkg;

    localparam longint ONE30 = 64'sd1 <<< 30;
    localparam longint ONE60 = 64'sd1 <<< 60;

    typedef struct {
        logic signed [16:0] roll;
        logic signed [15:0] pitch;
        logic signed [16:0] yaw;
    } euler_t;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring CORDIC, degrees in Q24
    function automatic longint atan2_deg(longint y, longint x);
        longint a;
        longint t;
        longint dx;
        longint dy;
        a = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                a = 64'sd90 <<< q2e_pkg::DEG_FRAC;
            end
            else
            begin
                x = -y;
                y = t;
                a = -(64'sd90 <<< q2e_pkg::DEG_FRAC);
            end
        end
        for (int i = 0; i < q2e_pkg::CORDIC_STAGES; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                a += longint'(q2e_pkg::ATAN_TAB[i]);
            end
            else if (y < 0)
            begin
                x -= dx;
                y += dy;
                a -= longint'(q2e_pkg::ATAN_TAB[i]);
            end
        end
        return a;
    endfunction

    function automatic longint round_angle(longint a, longint lim_deg);
        int s;
        s = q2e_pkg::RND_SHIFT;
        return clamp_sym(floor_shr(a + (64'sd1 <<< (s - 1)), s),
                         lim_deg <<< q2e_pkg::ANGLE_FRAC_BITS);
    endfunction

    function automatic euler_t predict_angles(logic [31:0] rx, logic [31:0] ry,
                                              logic [31:0] rz);
        longint x, y, z, w, t0, t1, t2, t3, t4, ts, c;
        longint unsigned sq;
        euler_t e;
        x = clamp_sym(longint'($signed(rx)), ONE30);
        y = clamp_sym(longint'($signed(ry)), ONE30);
        z = clamp_sym(longint'($signed(rz)), ONE30);
        sq = x * x + y * y + z * z;
        if (sq >= ONE60)
            w = 0;
        else
            w = int_sqrt(ONE60 - sq);
        t0 = 2 * (w * x + y * z);
        t1 = ONE60 - 2 * (x * x + y * y);
        t2 = clamp_sym(2 * (w * y - z * x), ONE60);
        t3 = 2 * (w * z + x * y);
        t4 = ONE60 - 2 * (y * y + z * z);
        ts = clamp_sym(floor_shr(t2 + (64'sd1 <<< 29), 30), ONE30);
        c = int_sqrt(ONE60 - ts * ts);
        e.roll = 17'(round_angle(atan2_deg(floor_shr(t0, 32), floor_shr(t1, 32)), 180));
        e.pitch = 16'(round_angle(atan2_deg(ts, c), 90));
        e.yaw = 17'(round_angle(atan2_deg(floor_shr(t3, 32), floor_shr(t4, 32)), 180));
        return e;
    endfunction

endpackage

// ----- bench/q2e_checker.sv -----
// Watches the sample and angle channels, predicts and compares angles.
// Depends on q2e_tb_pkg, q2e_in_if and q2e_out_if.
module q2e_checker (
    input  logic      clk,
    input  logic      rst_n,
    q2e_in_if         samples,
    q2e_out_if        angles,
    output int        errors,
    output int        pending,
    output int        seen
);
    timeunit 1ns;
    timeprecision 1ps;

    q2e_tb_pkg::euler_t angles_due[$];

    assign pending = angles_due.size();

    initial
    begin
        errors = 0;
        seen = 0;
    end

    always @(posedge clk)
    begin
        q2e_tb_pkg::euler_t e;
        if (rst_n && samples.valid && samples.ready && samples.quat_valid)
            angles_due.push_back(q2e_tb_pkg::predict_angles(samples.quat_x, samples.quat_y,
                                                            samples.quat_z));
        if (rst_n && angles.valid && angles.ready)
        begin
            seen++;
            if (angles_due.size() == 0)
            begin
                $error("unexpected angle result");
                errors++;
            end
            else
            begin
                e = angles_due.pop_front();
                if (angles.roll_deg !== e.roll)
                begin
                    $error("roll_deg expected %0d got %0d", e.roll, angles.roll_deg);
                    errors++;
                end
                if (angles.pitch_deg !== e.pitch)
                begin
                    $error("pitch_deg expected %0d got %0d", e.pitch, angles.pitch_deg);
                    errors++;
                end
                if (angles.yaw_deg !== e.yaw)
                begin
                    $error("yaw_deg expected %0d got %0d", e.yaw, angles.yaw_deg);
                    errors++;
                end
            end
        end
    end
endmodule

// ----- bench/tb.sv -----
// Top of the bench: clock, reset, sample stimulus, output back-pressure, verdict.
// Depends on q2e_pkg, the channel interfaces, q2e_checker and the unit itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = q2e_pkg::PIPE_DEPTH + 1;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   seen;
    int   cycles = 0;
    int   send_idle_pct = 8;   // chance per cycle that the sender idles
    int   recv_idle_pct = 59;  // chance per cycle that the receiver stalls
    bit   hold_off = 1'b0;     // long back-pressure window
    int   sent = 0;
    int   dropped = 0;

    q2e_in_if  samples ();
    q2e_out_if angles ();

    quaternion_to_euler_angles_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .angles  (angles)
    );

    q2e_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .angles  (angles),
        .errors  (errors),
        .pending (pending),
        .seen    (seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run; the limit covers every stall at its worst many times over.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quaternion_to_euler_angles_unit: mismatch");
            $finish;
        end
    end

    // Receiver: stall at random, or hold ready low for the whole hold-off window.
    initial
        angles.ready = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            angles.ready <= 1'b0;
        else
            angles.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Clamp-range-heavy random component: extremes, near-zero, in-range and full 32-bit noise.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(9))
            0: return 32'sd1073741824;
            1: return -32'sd1073741824;
            2: return $urandom();
            3: return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
        endcase
    endfunction

    // Random unit quaternion vector part: pick four random components and normalise them.
    function automatic void rand_unit(output logic [31:0] x, output logic [31:0] y,
                                      output logic [31:0] z);
        real a, b, c, n;
        real w;
        a = ($urandom() / 4294967295.0) * 2.0 - 1.0;
        b = ($urandom() / 4294967295.0) * 2.0 - 1.0;
        c = ($urandom() / 4294967295.0) * 2.0 - 1.0;
        w = ($urandom() / 4294967295.0) * 2.0 - 1.0;
        n = $sqrt(a * a + b * b + c * c + w * w);
        if (n < 1.0e-6)
            n = 1.0;
        x = 32'($rtoi(a / n * 1073741824.0));
        y = 32'($rtoi(b / n * 1073741824.0));
        z = 32'($rtoi(c / n * 1073741824.0));
    endfunction

    // Offer one request and hold it until the unit takes it.
    task automatic send_sample(logic qv, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid      <= 1'b1;
        samples.quat_valid <= qv;
        samples.quat_x     <= x;
        samples.quat_y     <= y;
        samples.quat_z     <= z;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        if (qv)
            sent++;
        else
            dropped++;
    endtask

    task automatic random_phase(int n);
        logic [31:0] x, y, z;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 70)
                rand_unit(x, y, z);
            else
            begin
                x = rand_comp();
                y = rand_comp();
                z = rand_comp();
            end
            send_sample($urandom_range(99) < 88, x, y, z);
        end
        samples.valid <= 1'b0;
    endtask

    localparam logic [31:0] P1 = 32'sd1073741824;
    localparam logic [31:0] N1 = -32'sd1073741824;
    localparam logic [31:0] H  = 32'sd759250125;   // sqrt(1/2) in Q30

    initial
    begin
        int wait_cycles;
        samples.valid      = 1'b0;
        samples.quat_valid = 1'b0;
        samples.quat_x     = '0;
        samples.quat_y     = '0;
        samples.quat_z     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, axis extremes, gimbal lock, norm above one,
        // out-of-range raw fields, zero-operand atan2 and the +180 branch.
        send_sample(1'b1, 32'd0, 32'd0, 32'd0);
        send_sample(1'b1, P1, 32'd0, 32'd0);
        send_sample(1'b1, N1, 32'd0, 32'd0);
        send_sample(1'b1, 32'd0, P1, 32'd0);
        send_sample(1'b1, 32'd0, N1, 32'd0);
        send_sample(1'b1, 32'd0, 32'd0, P1);
        send_sample(1'b1, 32'd0, 32'd0, N1);
        send_sample(1'b1, 32'd0, H, 32'd0);
        send_sample(1'b1, 32'd0, -H, 32'd0);
        send_sample(1'b1, H, 32'd0, H);
        send_sample(1'b1, P1, P1, P1);
        send_sample(1'b1, N1, N1, N1);
        send_sample(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(1'b1, H, H, 32'd0);
        send_sample(1'b1, 32'd1, 32'hFFFF_FFFF, 32'd1);
        send_sample(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'd0, 32'd0, 32'd0);
        samples.valid <= 1'b0;

        random_phase(450);

        // Long back-pressure: keep offering while ready stays low so the pipe fills.
        hold_off <= 1'b1;
        fork
            begin
                wait_cycles = 0;
                while (wait_cycles < 3 * LATENCY)
                begin
                    @(posedge clk);
                    wait_cycles++;
                end
                hold_off <= 1'b0;
            end
            random_phase(150);
        join

        send_idle_pct = 59;
        recv_idle_pct = 8;
        random_phase(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(400);

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);

        $display("Sent %0d valid and %0d invalid samples; checked %0d angle sets",
                 sent, dropped, seen);
        $display("under random stalls on both sides and one long output hold-off.");
        if (errors == 0 && pending == 0)
            $display("quaternion_to_euler_angles_unit: match");
        else
            $display("quaternion_to_euler_angles_unit: mismatch");
        $finish;
    end
endmodule
